// File: sv/itb_pkg.sv
package itb_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int TICK_BITS  = 32;
   localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_DISARM = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  slot;
      logic [6:0]  signal_number;
      logic [31:0] first_ticks;
      logic [31:0] reload_ticks;
      logic [15:0] owner_id;
   } req_type;

   typedef struct packed {
      logic [15:0] owner_id_out;
      logic [6:0]  signal_out;
      logic [2:0]  slot_out;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 accept;
      logic                 scan;
      logic                 advance;
      logic [SLOT_BITS-1:0] idx;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

endpackage

// File: sv/itb_ctrl.sv
module itb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_stall,
   input  itb_pkg::status_type  status,
   output itb_pkg::cmd_type     cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                    state_ff, state_in;
   logic [itb_pkg::SLOT_BITS-1:0] idx_ff, idx_in;
   logic                         accept;
   logic                         advance;
   logic                         last_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // A slot that would emit waits until the output register can take its result.
   assign advance   = (state_ff == ST_SCAN) && (!status.emit || status.out_free);
   assign last_idx  = (idx_ff == itb_pkg::SLOT_BITS'(itb_pkg::SLOT_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept && req_op == itb_pkg::OP_TICK) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign cmd.accept  = accept;
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign cmd.advance = advance;
   assign cmd.idx     = idx_ff;

endmodule

// File: sv/itb_dp.sv
module itb_dp (
   input  logic                clock,
   input  logic                reset,
   input  itb_pkg::req_type    req_data,
   input  itb_pkg::cmd_type    cmd,
   output itb_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output itb_pkg::rsp_type    rsp_data
);

   localparam int N = itb_pkg::SLOT_COUNT;
   localparam int W = itb_pkg::TICK_BITS;

   logic                          active_ff [N];
   logic [6:0]                    signal_ff [N];
   logic [W-1:0]                  countdown_ff [N];
   logic [W-1:0]                  reload_ff [N];
   logic [15:0]                   owner_ff [N];
   logic [N-1:0]                  mask_ff, mask_in;
   logic                          rsp_valid_ff;
   itb_pkg::rsp_type              rsp_data_ff;

   logic [itb_pkg::SLOT_BITS-1:0] req_idx;
   logic                          req_in_range;
   logic                          cur_active;
   logic [W-1:0]                  cur_count;
   logic                          counting;
   logic                          hits;
   logic                          emit;
   logic                          last;
   logic [N-1:0]                  higher;

   assign req_idx      = itb_pkg::SLOT_BITS'(req_data.slot);
   assign req_in_range = (32'(req_data.slot) < itb_pkg::SLOT_COUNT);

   assign cur_active = active_ff[cmd.idx];
   assign cur_count  = countdown_ff[cmd.idx];
   assign counting   = cur_active && (cur_count != '0);
   assign hits       = counting && (cur_count == W'(1));
   assign emit       = cmd.scan && hits && (owner_ff[cmd.idx] != 16'd0);

   // The expiry mask is captured when the tick is taken, so the result of the
   // highest emitting slot can be marked as last without looking ahead.
   assign higher = mask_ff >> cmd.idx;
   assign last   = ((higher >> 1) == '0);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         mask_in[i] = active_ff[i] && (countdown_ff[i] == W'(1)) && (owner_ff[i] != 16'd0);
      end
   end

   assign status.emit     = emit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            active_ff[i] <= 1'b0;
         end
         mask_ff <= '0;
      end else begin
         if (cmd.accept && req_data.op == itb_pkg::OP_TICK) begin
            mask_ff <= mask_in;
         end
         if (cmd.accept && req_in_range) begin
            if (req_data.op == itb_pkg::OP_ARM) begin
               active_ff[req_idx] <= 1'b1;
            end else if (req_data.op == itb_pkg::OP_DISARM) begin
               active_ff[req_idx] <= 1'b0;
            end
         end
         if (cmd.advance && hits && reload_ff[cmd.idx] == '0) begin
            active_ff[cmd.idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_in_range && req_data.op == itb_pkg::OP_ARM) begin
         signal_ff[req_idx]    <= req_data.signal_number;
         countdown_ff[req_idx] <= W'(req_data.first_ticks);
         reload_ff[req_idx]    <= W'(req_data.reload_ticks);
         owner_ff[req_idx]     <= req_data.owner_id;
      end else if (cmd.advance && counting) begin
         // On expiry the reload value is zero for a one-shot slot, which leaves zero.
         countdown_ff[cmd.idx] <= hits ? reload_ff[cmd.idx] : (cur_count - W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && emit) begin
         rsp_data_ff.owner_id_out <= owner_ff[cmd.idx];
         rsp_data_ff.signal_out   <= signal_ff[cmd.idx];
         rsp_data_ff.slot_out     <= 3'(cmd.idx);
         rsp_data_ff.last         <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/interval_timer_bank_top.sv
// Interval timer bank: eight periodic or one-shot countdown timers behind one request channel.
// A request carries an op code: tick, arm a slot, or disarm a slot. Arm loads the
// slot's owner, signal number, first countdown and reload interval; disarm clears
// only the slot's active bit. Requests are accepted when req_valid is high and
// req_stall is low. Arm and disarm produce no response. After a tick is accepted,
// the controller visits the slots in ascending order through one shared decrement
// and compare unit. Each slot that expires with a nonzero owner sends one response
// with owner, signal and slot; the last response of a tick is marked. req_stall
// stays high while a tick is being scanned.
// Responses sit in an output register; when the receiver holds rsp_stall high,
// the scan pauses at the next expiring slot until the register is taken, so no
// response is lost. A stalled response holds its value.
// Synchronous reset marks every slot inactive and empties the output register.
module interval_timer_bank_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  itb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output itb_pkg::rsp_type rsp_data
);

   itb_pkg::cmd_type    cmd;
   itb_pkg::status_type status;

   // The controller sequences the slot scan; the datapath holds the slot state.
   itb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A held response must never be overwritten by a new expiry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.advance && status.emit))
      else $error("response overwritten while stalled");

   // An accepted tick always starts a scan in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_data.op == itb_pkg::OP_TICK) |=> cmd.scan)
      else $error("tick accepted without a scan");

   // No request is taken while a scan is running.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !cmd.accept)
      else $error("request accepted during scan");

endmodule
